### src/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants, codes and controller/datapath types for the two-way
// sorted merge block.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int OP_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FIRST  = 2'd0,
        OP_PUSH_SECOND = 2'd1,
        OP_MERGE       = 2'd2
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic push_first;
        logic push_second;
        logic issue;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic slot_free;
        logic last;
    } t_dp_stat;

endpackage

### src/swm_in_if.sv
// ----------------------------------------------------------------------------
// swm_in_if
// Command channel: op code and pushed value with valid/ready handshake.
// ----------------------------------------------------------------------------
interface swm_in_if;
    logic                        valid;
    logic                        ready;
    logic [swm_pkg::OP_W-1:0]    op;
    logic [swm_pkg::DATA_W-1:0]  value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

### src/swm_out_if.sv
// ----------------------------------------------------------------------------
// swm_out_if
// Result channel: merged values with source, last, empty and overflow flags.
// ----------------------------------------------------------------------------
interface swm_out_if;
    logic                        valid;
    logic                        ready;
    logic [swm_pkg::DATA_W-1:0]  value_res;
    logic                        from_second_list;
    logic                        last;
    logic                        empty_res;
    logic                        overflow;

    modport source (output valid, output value_res, output from_second_list,
                    output last, output empty_res, output overflow, input ready);
    modport sink   (input valid, input value_res, input from_second_list,
                    input last, input empty_res, input overflow, output ready);
endinterface

### src/swm_ctrl.sv
// ----------------------------------------------------------------------------
// swm_ctrl
// Controller: accepts pushes while idle, runs a merge one result per cycle
// whenever the output slot is free, returns to idle after the last result.
// ----------------------------------------------------------------------------
module swm_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [swm_pkg::OP_W-1:0]  i_op,
    output logic                      o_in_ready,
    input  swm_pkg::t_dp_stat         i_stat,
    output swm_pkg::t_dp_cmd          o_cmd
);

    swm_pkg::t_state r_state;
    swm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            swm_pkg::ST_IDLE: begin
                if (i_in_valid && (i_op == swm_pkg::OP_MERGE)) begin
                    n_state = swm_pkg::ST_MERGE;
                end
            end
            swm_pkg::ST_MERGE: begin
                if (i_stat.slot_free && i_stat.last) begin
                    n_state = swm_pkg::ST_IDLE;
                end
            end
            default: n_state = swm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready        = 1'b0;
        o_cmd.push_first  = 1'b0;
        o_cmd.push_second = 1'b0;
        o_cmd.issue       = 1'b0;
        case (r_state)
            swm_pkg::ST_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.push_first  = i_in_valid && (i_op == swm_pkg::OP_PUSH_FIRST);
                o_cmd.push_second = i_in_valid && (i_op == swm_pkg::OP_PUSH_SECOND);
            end
            swm_pkg::ST_MERGE: begin
                o_cmd.issue = i_stat.slot_free;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

### src/swm_dp.sv
// ----------------------------------------------------------------------------
// swm_dp
// Datapath: two stores with registered head reads, fill counts, read
// pointers, head compare and the result output register.
// ----------------------------------------------------------------------------
module swm_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [swm_pkg::DATA_W-1:0]   i_value,
    input  swm_pkg::t_dp_cmd             i_cmd,
    output swm_pkg::t_dp_stat            o_stat,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [swm_pkg::DATA_W-1:0]   o_value_res,
    output logic                         o_from_second_list,
    output logic                         o_last,
    output logic                         o_empty_res,
    output logic                         o_overflow
);

    localparam int CW = swm_pkg::CNT_W;
    localparam int IW = swm_pkg::IDX_W;
    localparam int DW = swm_pkg::DATA_W;

    logic [DW-1:0] r_mem_a [swm_pkg::DEPTH];
    logic [DW-1:0] r_mem_b [swm_pkg::DEPTH];

    logic [DW-1:0] r_head_a, r_head_b;
    logic [CW-1:0] r_cnt_a, r_cnt_b, n_cnt_a, n_cnt_b;
    logic [CW-1:0] r_ptr_a, r_ptr_b, n_ptr_a, n_ptr_b;
    logic [CW-1:0] nxt_a, nxt_b;
    logic          r_ovf, n_ovf;
    logic          r_out_valid, n_out_valid;

    logic          full_a, full_b;
    logic          a_avail, b_avail, take_a, take_b;
    logic          last;
    logic          slot_free;
    logic          wr_a, wr_b;

    assign full_a  = (r_cnt_a == CW'(swm_pkg::DEPTH));
    assign full_b  = (r_cnt_b == CW'(swm_pkg::DEPTH));
    assign wr_a    = i_cmd.push_first  && !full_a;
    assign wr_b    = i_cmd.push_second && !full_b;

    assign a_avail = (r_ptr_a < r_cnt_a);
    assign b_avail = (r_ptr_b < r_cnt_b);
    // on equal heads the second store wins
    assign take_a  = a_avail && (!b_avail || (r_head_a < r_head_b));
    assign take_b  = b_avail && !take_a;
    assign nxt_a   = r_ptr_a + CW'(take_a);
    assign nxt_b   = r_ptr_b + CW'(take_b);
    // both stores drained after this transfer (also true when both are empty)
    assign last    = (nxt_a == r_cnt_a) && (nxt_b == r_cnt_b);

    assign slot_free        = !r_out_valid || i_out_ready;
    assign o_stat.slot_free = slot_free;
    assign o_stat.last      = last;

    always_comb begin
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_ptr_a     = r_ptr_a;
        n_ptr_b     = r_ptr_b;
        n_ovf       = r_ovf;
        n_out_valid = i_out_ready ? 1'b0 : r_out_valid;
        if (wr_a) begin
            n_cnt_a = r_cnt_a + CW'(1);
        end
        if (wr_b) begin
            n_cnt_b = r_cnt_b + CW'(1);
        end
        if ((i_cmd.push_first && full_a) || (i_cmd.push_second && full_b)) begin
            n_ovf = 1'b1;
        end
        if (i_cmd.issue) begin
            n_out_valid = 1'b1;
            if (last) begin
                n_cnt_a = '0;
                n_cnt_b = '0;
                n_ptr_a = '0;
                n_ptr_b = '0;
                n_ovf   = 1'b0;
            end else begin
                n_ptr_a = nxt_a;
                n_ptr_b = nxt_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_ptr_a     <= '0;
            r_ptr_b     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_ptr_a     <= n_ptr_a;
            r_ptr_b     <= n_ptr_b;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // stores: one write port, one registered read at the next pointer,
    // so the head register always holds the entry at the current pointer
    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            r_mem_a[r_cnt_a[IW-1:0]] <= i_value;
        end
        r_head_a <= r_mem_a[n_ptr_a[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            r_mem_b[r_cnt_b[IW-1:0]] <= i_value;
        end
        r_head_b <= r_mem_b[n_ptr_b[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            o_value_res        <= take_a ? r_head_a : (take_b ? r_head_b : '0);
            o_from_second_list <= take_b;
            o_last             <= last;
            o_empty_res        <= !a_avail && !b_avail;
            o_overflow         <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### src/sorted_two_way_merge.sv
// ----------------------------------------------------------------------------
// sorted_two_way_merge
// Two bounded stores loaded by push commands; a merge command emits all
// stored values in ascending order and clears both stores.
//
//   channel | dir | handshake     | payload
//   i_in    | in  | valid / ready | op, value
//   o_out   | out | valid / ready | value_res, from_second_list, last,
//           |     |               | empty_res, overflow
//
// Pushes are accepted back to back while idle.
// A merge of N stored values (N >= 1, or one empty result) emits one result
// per cycle from a single output register while the sink does not stall;
// input ready is low for the whole run.
// Output stalls hold the run in place. Reset is synchronous, active low,
// and clears counts, pointers and flags only; store contents need no clearing.
// ----------------------------------------------------------------------------
module sorted_two_way_merge (
    input  logic      i_clk,
    input  logic      i_rst_n,
    swm_in_if.sink    i_in,
    swm_out_if.source o_out
);

    swm_pkg::t_dp_cmd  cmd;
    swm_pkg::t_dp_stat stat;

    swm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_op       (i_in.op),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    swm_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_value            (i_in.value),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_value_res        (o_out.value_res),
        .o_from_second_list (o_out.from_second_list),
        .o_last             (o_out.last),
        .o_empty_res        (o_out.empty_res),
        .o_overflow         (o_out.overflow)
    );

endmodule

### tb/tb_sorted_two_way_merge.sv
// ----------------------------------------------------------------------------
// tb_sorted_two_way_merge
// Self-checking bench for the two-way sorted merge. A directed table covers
// empty merges, the unused op code, extreme values, equal heads and unsorted
// input. Random sequences of sorted pushes, overflowing pushes and noise
// follow. Every merge result is checked against an in-bench predictor or a typed-in expectation.
// ----------------------------------------------------------------------------
module tb_sorted_two_way_merge;
    timeunit 1ns;
    timeprecision 1ps;

    import swm_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS    = 210;
    localparam int HOLD_CYCLES     = 150;
    localparam int DRAIN_CYCLES    = 20;
    localparam int N_DIRECTED      = 22;

    typedef struct packed {
        logic [DATA_W-1:0] value_res;
        logic              from_second_list;
        logic              last;
        logic              empty_res;
        logic              overflow;
    } merge_out_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
        logic              typed;
        merge_out_t        want;
    } stim_row_t;

    localparam merge_out_t NO_RES    = '0;
    localparam merge_out_t EMPTY_RUN = '{32'h0, 1'b0, 1'b1, 1'b1, 1'b0};

    // expected result typed in where it is obvious, else from the predictor
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{OP_MERGE,       32'h0000_0000, 1'b1, EMPTY_RUN},  // empty after reset
        '{OP_UNUSED,      32'hFFFF_FFFF, 1'b0, NO_RES},
        '{OP_MERGE,       32'hFFFF_FFFF, 1'b1, EMPTY_RUN},  // op 3 left no trace
        '{OP_PUSH_FIRST,  32'h0000_0000, 1'b0, NO_RES},
        '{OP_PUSH_SECOND, 32'h0000_0000, 1'b0, NO_RES},
        '{OP_PUSH_FIRST,  32'hFFFF_FFFF, 1'b0, NO_RES},
        '{OP_PUSH_SECOND, 32'h8000_0000, 1'b0, NO_RES},
        '{OP_PUSH_SECOND, 32'hFFFF_FFFF, 1'b0, NO_RES},
        '{OP_PUSH_SECOND, 32'h0000_0003, 1'b0, NO_RES},     // out of order
        '{OP_MERGE,       32'h1234_5678, 1'b0, NO_RES},
        '{OP_PUSH_FIRST,  32'h0000_0007, 1'b0, NO_RES},
        '{OP_MERGE,       32'h0000_0000, 1'b1, '{32'h7, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{OP_PUSH_SECOND, 32'hA5A5_A5A5, 1'b0, NO_RES},
        '{OP_MERGE,       32'h0000_0000, 1'b1, '{32'hA5A5_A5A5, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{OP_PUSH_FIRST,  32'h5A5A_5A5A, 1'b0, NO_RES},
        '{OP_UNUSED,      32'h0000_0000, 1'b0, NO_RES},
        '{OP_PUSH_SECOND, 32'h5A5A_5A5A, 1'b0, NO_RES},     // equal heads
        '{OP_PUSH_FIRST,  32'h5A5A_5A5B, 1'b0, NO_RES},
        '{OP_MERGE,       32'h0000_0000, 1'b0, NO_RES},
        '{OP_PUSH_FIRST,  32'h0000_0001, 1'b0, NO_RES},
        '{OP_PUSH_FIRST,  32'h0000_0002, 1'b0, NO_RES},
        '{OP_MERGE,       32'h0000_0000, 1'b0, NO_RES}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    swm_in_if  in_ch ();
    swm_out_if out_ch ();

    sorted_two_way_merge DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // predictor state
    logic [DATA_W-1:0] first_list[$];
    logic [DATA_W-1:0] second_list[$];
    logic              push_dropped = 1'b0;
    merge_out_t        merged_due[$];

    int  mismatches   = 0;
    int  work_items   = 0;
    bit  src_calm     = 1'b0;
    bit  pressure_arm = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void predict_merge_item(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
        int         ia;
        int         ib;
        int         total;
        logic       take_first;
        merge_out_t r;
        ia = 0;
        ib = 0;
        case (op)
            OP_PUSH_FIRST: begin
                if (first_list.size() < DEPTH) first_list.push_back(val);
                else push_dropped = 1'b1;
            end
            OP_PUSH_SECOND: begin
                if (second_list.size() < DEPTH) second_list.push_back(val);
                else push_dropped = 1'b1;
            end
            OP_MERGE: begin
                total = first_list.size() + second_list.size();
                if (total == 0) begin
                    r = EMPTY_RUN;
                    r.overflow = push_dropped;
                    merged_due.push_back(r);
                end
                while (ia < first_list.size() || ib < second_list.size()) begin
                    // second list wins ties
                    if (ia < first_list.size() && ib < second_list.size()) begin
                        take_first = first_list[ia] < second_list[ib];
                    end else begin
                        take_first = ia < first_list.size();
                    end
                    r.last      = (ia + ib + 1 == total);
                    r.empty_res = 1'b0;
                    r.overflow  = push_dropped;
                    if (take_first) begin
                        r.value_res        = first_list[ia];
                        r.from_second_list = 1'b0;
                        ia++;
                    end else begin
                        r.value_res        = second_list[ib];
                        r.from_second_list = 1'b1;
                        ib++;
                    end
                    merged_due.push_back(r);
                end
                first_list.delete();
                second_list.delete();
                push_dropped = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                             input logic typed = 1'b0, input merge_out_t want = '0);
        int gap;
        gap = src_calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op    <= op;
        in_ch.value <= val;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        predict_merge_item(op, val);
        if (typed) begin
            void'(merged_due.pop_back());
            merged_due.push_back(want);
        end
        if (op != OP_UNUSED) work_items++;
        @(negedge i_clk);
    endtask

    task automatic build_ascending(input int n, input logic dense, ref logic [DATA_W-1:0] q[$]);
        logic [63:0] acc;
        logic [63:0] step_max;
        int          i;
        q.delete();
        if (dense) begin
            acc = 64'($urandom_range(0, 4));
            step_max = 64'd2;
        end else begin
            acc = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 255)) : 64'($urandom);
            step_max = (n > 0) ? (64'hFFFF_FFFF - acc) / 64'(n) : 64'd0;
        end
        for (i = 0; i < n; i++) begin
            q.push_back(acc[DATA_W-1:0]);
            acc += 64'($urandom_range(0, step_max[DATA_W-1:0]));
        end
    endtask

    // sorted pushes to both lists, interleaved at random with occasional unused ops, then a merge
    task automatic run_sorted_merge(input int n_a, input int n_b, input logic dense);
        logic [DATA_W-1:0] seq_a[$];
        logic [DATA_W-1:0] seq_b[$];
        int                ia;
        int                ib;
        ia = 0;
        ib = 0;
        build_ascending(n_a, dense, seq_a);
        build_ascending(n_b, dense, seq_b);
        while (ia < n_a || ib < n_b) begin
            if ($urandom_range(0, 15) == 0) send_item(OP_UNUSED, $urandom);
            if (ia < n_a && (ib >= n_b || $urandom_range(0, 1) == 1)) begin
                send_item(OP_PUSH_FIRST, seq_a[ia]);
                ia++;
            end else begin
                send_item(OP_PUSH_SECOND, seq_b[ib]);
                ib++;
            end
        end
        send_item(OP_MERGE, $urandom);
    endtask

    function automatic int pick_size();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(0, DEPTH) : $urandom_range(0, 5);
    endfunction

    initial begin : stimulus
        int i;
        int base;
        int kind;
        int n;
        in_ch.valid = 1'b0;
        in_ch.op    = OP_PUSH_FIRST;
        in_ch.value = '0;
        @(posedge i_rst_n);
        @(negedge i_clk);

        for (i = 0; i < N_DIRECTED; i++) begin
            send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].value,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end

        // both lists overflow while the result side is held off
        pressure_arm = 1'b1;
        src_calm     = 1'b1;
        run_sorted_merge(DEPTH + 1, DEPTH + 1, 1'($urandom_range(0, 1)));

        base = work_items;
        while (work_items - base < RANDOM_ITEMS) begin
            src_calm = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                run_sorted_merge(pick_size(), pick_size(), 1'($urandom_range(0, 1)));
            end else if (kind < 82) begin
                run_sorted_merge(DEPTH + $urandom_range(0, 2), pick_size(),
                                 1'($urandom_range(0, 1)));
            end else begin
                n = $urandom_range(1, 10);
                for (i = 0; i < n; i++) send_item(OP_W'($urandom_range(0, 3)), $urandom);
                send_item(OP_MERGE, $urandom);
            end
        end
        in_ch.valid <= 1'b0;

        while (merged_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[sorted_two_way_merge] OK");
        end else begin
            $display("[sorted_two_way_merge] ERROR");
        end
        $finish;
    end

    // result side: random stalls, calm stretches, one long hold-off
    initial begin : result_sink
        int  stall_left;
        int  phase_left;
        bit  sink_calm;
        bit  pressure_done;
        stall_left    = 0;
        phase_left    = 0;
        sink_calm     = 1'b0;
        pressure_done = 1'b0;
        out_ch.ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (phase_left == 0) begin
                sink_calm  = ($urandom_range(0, 3) == 0);
                phase_left = $urandom_range(40, 200);
            end
            phase_left--;
            if (pressure_arm && !pressure_done) begin
                out_ch.ready <= 1'b0;
                pressure_done = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (!sink_calm) stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        merge_out_t want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (merged_due.size() == 0) begin
                $display("%0t: result with none expected: value_res=%h", $time,
                         out_ch.value_res);
                mismatches++;
            end else begin
                want = merged_due.pop_front();
                if (out_ch.value_res !== want.value_res) begin
                    $display("%0t: value_res expected %h actual %h", $time,
                             want.value_res, out_ch.value_res);
                    mismatches++;
                end
                if (out_ch.from_second_list !== want.from_second_list) begin
                    $display("%0t: from_second_list expected %b actual %b", $time,
                             want.from_second_list, out_ch.from_second_list);
                    mismatches++;
                end
                if (out_ch.last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time,
                             want.last, out_ch.last);
                    mismatches++;
                end
                if (out_ch.empty_res !== want.empty_res) begin
                    $display("%0t: empty_res expected %b actual %b", $time,
                             want.empty_res, out_ch.empty_res);
                    mismatches++;
                end
                if (out_ch.overflow !== want.overflow) begin
                    $display("%0t: overflow expected %b actual %b", $time,
                             want.overflow, out_ch.overflow);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("[sorted_two_way_merge] ERROR");
        $finish;
    end

endmodule
